/* sv/fmdr_pkg.sv */
// Shared types and constants for the fraction multiply/divide/reduce unit.
`timescale 1ns / 1ps
`default_nettype none

package fmdr_pkg;

    // Width of the reduced result fields
    localparam int RES_WIDTH = 32;

    // Command codes
    localparam logic CMD_MUL = 1'b0;
    localparam logic CMD_DIV = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_MUL_D,
        ST_CHECK,
        ST_TWOS,
        ST_GCD,
        ST_DIVN_GO,
        ST_DIVN_WAIT,
        ST_DIVD_GO,
        ST_DIVD_WAIT
    } state_t;

    // Status of the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

/* sv/fraction_mul_div_reduce_unit.sv */
// Top level: multiply or divide two fractions and reduce the result by its GCD.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  command  | start, busy           | command, a_num, a_den, b_num, b_den
//  result   | done (one-cycle pulse)| res_num, res_den, zero_zero_error
//
// An item is taken when start is high and busy is low; busy then stays high.
// busy covers setup, the two serial divisions, the loop exits and a
// data-dependent binary GCD loop on one shared compare/subtract/shift unit;
// an item whose products are both zero skips the loop and both divisions.
// done rises in the cycle busy falls, so a new start may be taken in that cycle.
// The receiver cannot stall; results stay on the ports until the next result.
// Reset clears the sequencer and the strobe.
`timescale 1ns / 1ps
`default_nettype none

module fraction_mul_div_reduce_unit #(
    parameter int IN_WIDTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  command,
    input  wire logic signed [IN_WIDTH-1:0]            a_num,
    input  wire logic signed [IN_WIDTH-1:0]            a_den,
    input  wire logic signed [IN_WIDTH-1:0]            b_num,
    input  wire logic signed [IN_WIDTH-1:0]            b_den,
    output logic                                       done,
    output logic signed [fmdr_pkg::RES_WIDTH-1:0]      res_num,
    output logic signed [fmdr_pkg::RES_WIDTH-1:0]      res_den,
    output logic                                       zero_zero_error
);
    import fmdr_pkg::*;

    localparam int PW = 2 * IN_WIDTH;
    localparam int KW = $clog2(PW);

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    logic                       cmd_reg, cmd_next;
    logic signed [IN_WIDTH-1:0] an_reg, an_next;
    logic signed [IN_WIDTH-1:0] ad_reg, ad_next;
    logic signed [IN_WIDTH-1:0] bn_reg, bn_next;
    logic signed [IN_WIDTH-1:0] bd_reg, bd_next;
    logic signed [PW-1:0]       n_reg, n_next;
    logic signed [PW-1:0]       d_reg, d_next;
    logic [PW-1:0]              u_reg, u_next;
    logic [PW-1:0]              v_reg, v_next;
    logic [KW-1:0]              k_reg, k_next;
    logic [PW-1:0]              g_reg, g_next;
    logic [PW-1:0]              qn_reg, qn_next;
    logic [RES_WIDTH-1:0]       rn_reg, rn_next;
    logic [RES_WIDTH-1:0]       rd_reg, rd_next;
    logic                       err_reg, err_next;

    logic signed [IN_WIDTH-1:0] mul_x;
    logic signed [IN_WIDTH-1:0] mul_y;
    logic signed [PW-1:0]       mul_p;
    logic [PW-1:0]              mag_n;
    logic [PW-1:0]              mag_d;
    logic                       u_ge_v;
    logic [PW-1:0]              sub_diff;
    logic [PW-1:0]              g_base;
    logic [PW-1:0]              sq_n;
    logic [PW-1:0]              sq_d;

    logic                       div_start;
    logic [PW-1:0]              div_dividend;
    logic [PW-1:0]              div_quotient;
    div_stat_t                  div_stat;

    // Shared multiplier: numerator product first, denominator product next
    always_comb
    begin
        if (state_reg == ST_MUL_N)
        begin
            mul_x = an_reg;
            mul_y = (cmd_reg == CMD_DIV) ? bd_reg : bn_reg;
        end
        else
        begin
            mul_x = ad_reg;
            mul_y = (cmd_reg == CMD_DIV) ? bn_reg : bd_reg;
        end
        mul_p = PW'(mul_x) * PW'(mul_y);
    end

    // Magnitudes of the products and signed quotients
    always_comb
    begin
        mag_n = n_reg[PW-1] ? (~n_reg + 1'b1) : n_reg;
        mag_d = d_reg[PW-1] ? (~d_reg + 1'b1) : d_reg;
        sq_n  = n_reg[PW-1] ? (~qn_reg + 1'b1) : qn_reg;
        sq_d  = d_reg[PW-1] ? (~div_quotient + 1'b1) : div_quotient;
    end

    // Shared compare/subtract and GCD shift for the binary GCD loop
    always_comb
    begin
        u_ge_v   = (u_reg >= v_reg);
        sub_diff = u_ge_v ? (u_reg - v_reg) : (v_reg - u_reg);
        g_base   = (u_reg == '0) ? v_reg : u_reg;
    end

    assign div_dividend = (state_reg == ST_DIVD_GO) ? mag_d : mag_n;

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        div_start  = 1'b0;
        cmd_next   = cmd_reg;
        an_next    = an_reg;
        ad_next    = ad_reg;
        bn_next    = bn_reg;
        bd_next    = bd_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        qn_next    = qn_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        err_next   = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    an_next    = a_num;
                    ad_next    = a_den;
                    bn_next    = b_num;
                    bd_next    = b_den;
                    state_next = ST_MUL_N;
                end
            end
            ST_MUL_N:
            begin
                n_next     = mul_p;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                d_next     = mul_p;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // Both products zero: flag and drop to zeros
                if (n_reg == '0 && d_reg == '0)
                begin
                    rn_next    = '0;
                    rd_next    = '0;
                    err_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    u_next     = mag_n;
                    v_next     = mag_d;
                    k_next     = '0;
                    state_next = ST_TWOS;
                end
            end
            ST_TWOS:
            begin
                // Strip common factors of two
                if (u_reg == '0 || v_reg == '0 || u_reg[0] || v_reg[0])
                begin
                    state_next = ST_GCD;
                end
                else
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
            end
            ST_GCD:
            begin
                if (u_reg == '0 || v_reg == '0)
                begin
                    g_next     = g_base << k_reg;
                    state_next = ST_DIVN_GO;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_ge_v)
                begin
                    u_next = sub_diff;
                end
                else
                begin
                    v_next = sub_diff;
                end
            end
            ST_DIVN_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVN_WAIT;
            end
            ST_DIVN_WAIT:
            begin
                if (div_stat.done)
                begin
                    qn_next    = div_quotient;
                    state_next = ST_DIVD_GO;
                end
            end
            ST_DIVD_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVD_WAIT;
            end
            ST_DIVD_WAIT:
            begin
                if (div_stat.done)
                begin
                    rn_next    = RES_WIDTH'(signed'(sq_n));
                    rd_next    = RES_WIDTH'(signed'(sq_d));
                    err_next   = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        an_reg  <= an_next;
        ad_reg  <= ad_next;
        bn_reg  <= bn_next;
        bd_reg  <= bd_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
        k_reg   <= k_next;
        g_reg   <= g_next;
        qn_reg  <= qn_next;
        rn_reg  <= rn_next;
        rd_reg  <= rd_next;
        err_reg <= err_next;
    end

    // Exact division of both products by the GCD
    fmdr_div #(
        .W (PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (g_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign res_num         = rn_reg;
    assign res_den         = rd_reg;
    assign zero_zero_error = err_reg;

endmodule

`default_nettype wire

/* sv/fmdr_div.sv */
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps
`default_nettype none

module fmdr_div #(
    parameter int W = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [W-1:0]        dividend,
    input  wire logic [W-1:0]        divisor,
    output logic      [W-1:0]        quotient,
    output fmdr_pkg::div_stat_t      stat
);
    import fmdr_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [W:0]    shifted;
    logic [W:0]    trial;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        trial   = shifted - {1'b0, dvs_reg};
    end

    // Next state of the iteration
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next  = CW'(W);
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* sv/fmdr_checker.sv */
// Port-level checks for the fraction multiply/divide/reduce unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module fmdr_checker #(
    parameter int IN_WIDTH = 16
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 start,
    input wire logic                                 busy,
    input wire logic                                 command,
    input wire logic signed [IN_WIDTH-1:0]           a_num,
    input wire logic signed [IN_WIDTH-1:0]           a_den,
    input wire logic signed [IN_WIDTH-1:0]           b_num,
    input wire logic signed [IN_WIDTH-1:0]           b_den,
    input wire logic                                 done,
    input wire logic signed [fmdr_pkg::RES_WIDTH-1:0] res_num,
    input wire logic signed [fmdr_pkg::RES_WIDTH-1:0] res_den,
    input wire logic                                 zero_zero_error
);
    import fmdr_pkg::*;

    // Accepted transfer keeps the unit busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transfer");

    // Result strobe comes only once the unit is idle again
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Result strobe lasts a single cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Error result carries zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_zero_error) |-> (res_num == '0 && res_den == '0))
        else $error("zero-zero error with nonzero result");

    // Reduced fractions never come out as 0/0
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !zero_zero_error) |-> (res_num != '0 || res_den != '0))
        else $error("reduced result is 0/0 without error");

endmodule

bind fraction_mul_div_reduce_unit fmdr_checker #(
    .IN_WIDTH (IN_WIDTH)
) u_fmdr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .a_num           (a_num),
    .a_den           (a_den),
    .b_num           (b_num),
    .b_den           (b_den),
    .done            (done),
    .res_num         (res_num),
    .res_den         (res_den),
    .zero_zero_error (zero_zero_error)
);

`default_nettype wire

/* bench/tb_fraction_mul_div_reduce_unit.sv */
// Testbench for the fraction multiply/divide/reduce unit: directed and random checks.
`timescale 1ns / 1ps

module tb_fraction_mul_div_reduce_unit;

    import fmdr_pkg::*;

    localparam int IN_W        = 16;
    localparam int WD_LIMIT    = 4000;   // idle cycles tolerated without any transfer
    localparam int DRAIN_WAIT  = 300;    // longest item latency, with margin
    localparam int N_RANDOM    = 450;
    localparam int MAX_PRINTS  = 40;

    // One operand set as driven on the command ports
    typedef struct packed {
        logic            cmd;
        logic [IN_W-1:0] an;
        logic [IN_W-1:0] ad;
        logic [IN_W-1:0] bn;
        logic [IN_W-1:0] bd;
    } frac_op_t;

    // One reduced result
    typedef struct packed {
        logic [RES_WIDTH-1:0] num;
        logic [RES_WIDTH-1:0] den;
        logic                 zz_err;
    } frac_res_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic                        command = CMD_MUL;
    logic signed [IN_W-1:0]      a_num = '0;
    logic signed [IN_W-1:0]      a_den = '0;
    logic signed [IN_W-1:0]      b_num = '0;
    logic signed [IN_W-1:0]      b_den = '0;
    logic                        done;
    logic signed [RES_WIDTH-1:0] res_num;
    logic signed [RES_WIDTH-1:0] res_den;
    logic                        zero_zero_error;

    frac_op_t  operand_q[$];
    frac_res_t reduced_q[$];
    frac_op_t  cur_op;

    int n_items     = 0;
    int n_accepted  = 0;
    int n_mul       = 0;
    int n_div       = 0;
    int n_results   = 0;
    int n_zz_flag   = 0;
    int n_den_zero  = 0;
    int n_neg_den   = 0;
    int n_errors    = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    fraction_mul_div_reduce_unit #(
        .IN_WIDTH(IN_W)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .a_num          (a_num),
        .a_den          (a_den),
        .b_num          (b_num),
        .b_den          (b_den),
        .done           (done),
        .res_num        (res_num),
        .res_den        (res_den),
        .zero_zero_error(zero_zero_error)
    );

    // Form both products (crosswise for divide), then divide them by their gcd
    function automatic frac_res_t reduce_fraction(frac_op_t op);
        frac_res_t     r;
        longint        n;
        longint        d;
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        r = '0;
        if (op.cmd == CMD_DIV) begin
            n = longint'($signed(op.an)) * longint'($signed(op.bd));
            d = longint'($signed(op.ad)) * longint'($signed(op.bn));
        end
        else begin
            n = longint'($signed(op.an)) * longint'($signed(op.bn));
            d = longint'($signed(op.ad)) * longint'($signed(op.bd));
        end
        if (n == 0 && d == 0) begin
            r.zz_err = 1'b1;
            return r;
        end
        x = (n < 0) ? -n : n;
        y = (d < 0) ? -d : d;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        n = n / longint'(x);
        d = d / longint'(x);
        r.num = n[RES_WIDTH-1:0];
        r.den = d[RES_WIDTH-1:0];
        return r;
    endfunction

    // Mostly short gaps, some long ones, and bursts with no gap at all
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(8, 30);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 80) return $urandom_range(1, 4);
        if (r < 95) return $urandom_range(5, 60);
        return $urandom_range(80, 300);
    endfunction

    task automatic queue_op(input logic cmd, input int an, input int ad, input int bn,
                            input int bd);
        frac_op_t op;
        op.cmd = cmd;
        op.an  = an[IN_W-1:0];
        op.ad  = ad[IN_W-1:0];
        op.bn  = bn[IN_W-1:0];
        op.bd  = bd[IN_W-1:0];
        operand_q.push_back(op);
        n_items++;
    endtask

    // Draw one operand from the chosen value class
    function automatic int rand_operand(int cls, int factor);
        int v;
        case (cls)
            0: v = $signed(16'($urandom()));
            1: v = $urandom_range(0, 40) - 20;
            2: v = factor * ($urandom_range(0, 100) - 50);
            3: begin
                case ($urandom_range(0, 7))
                    0: v = -32768;
                    1: v = -32767;
                    2: v = -1;
                    3: v = 0;
                    4: v = 1;
                    5: v = 32767;
                    6: v = 16384;
                    default: v = -16384;
                endcase
            end
            default: begin
                v = 1 << $urandom_range(0, 14);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Drive operand sets; hold each one until the block takes it
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        frac_op_t nxt;
        if (!rst_n)
        begin
            start    <= 1'b0;
            command  <= CMD_MUL;
            a_num    <= '0;
            a_den    <= '0;
            b_num    <= '0;
            b_den    <= '0;
            gap_left = 0;
        end
        else if (!(start && busy))
        begin
            // record the transfer that completes at this edge
            if (start)
            begin
                reduced_q.push_back(reduce_fraction(cur_op));
                n_accepted++;
                if (cur_op.cmd == CMD_DIV) n_div++;
                else n_mul++;
                gap_left = pick_gap();
            end
            if (gap_left > 0 || operand_q.size() == 0)
            begin
                if (gap_left > 0) gap_left--;
                start <= 1'b0;
            end
            else
            begin
                nxt     = operand_q.pop_front();
                cur_op  = nxt;
                command <= nxt.cmd;
                a_num   <= nxt.an;
                a_den   <= nxt.ad;
                b_num   <= nxt.bn;
                b_den   <= nxt.bd;
                start   <= 1'b1;
            end
        end
    end

    // Compare each result strobe against the oldest prediction
    always @(posedge clk)
    begin : check_proc
        frac_res_t want;
        if (rst_n && done)
        begin
            if (reduced_q.size() == 0)
            begin
                report_mismatch("result with nothing pending", res_num, 0);
            end
            else
            begin
                want = reduced_q.pop_front();
                n_results++;
                if (want.zz_err) n_zz_flag++;
                else if (want.den == 0) n_den_zero++;
                else if (want.den[RES_WIDTH-1]) n_neg_den++;
                if (res_num !== want.num)
                    report_mismatch("res_num", res_num, $signed(want.num));
                if (res_den !== want.den)
                    report_mismatch("res_den", res_den, $signed(want.den));
                if (zero_zero_error !== want.zz_err)
                    report_mismatch("zero_zero_error", zero_zero_error, want.zz_err);
            end
        end
    end

    // Watchdog: stop if neither side transfers for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WD_LIMIT)
        begin
            $display("timeout after %0d idle cycles, %0d results pending",
                     idle_cycles, reduced_q.size());
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus, reset and end of run
    initial
    begin : main_proc
        int cls;
        int factor;
        logic cmd;

        // directed: extremes, both commands, zero products
        queue_op(CMD_MUL, 2, 3, 3, 4);
        queue_op(CMD_DIV, 2, 3, 4, 9);
        queue_op(CMD_MUL, 0, 5, 7, 0);              // both products zero
        queue_op(CMD_DIV, 0, 0, 3, 5);              // both products zero
        queue_op(CMD_MUL, 0, 0, 0, 0);
        queue_op(CMD_DIV, 0, 0, 0, 0);
        queue_op(CMD_MUL, 0, 5, 3, -7);             // numerator product zero only
        queue_op(CMD_DIV, 0, 9, 4, 6);
        queue_op(CMD_MUL, 3, 0, 5, 2);              // denominator product zero only
        queue_op(CMD_DIV, -6, 4, 0, 3);
        queue_op(CMD_MUL, -32768, -32768, -32768, -32768);
        queue_op(CMD_DIV, -32768, -32768, -32768, -32768);
        queue_op(CMD_MUL, -32768, 1, -32768, 1);
        queue_op(CMD_MUL, 1, -32768, 1, -32768);
        queue_op(CMD_DIV, -32768, 32767, 32767, -32768);
        queue_op(CMD_MUL, 32767, 32767, 32767, 32767);
        queue_op(CMD_MUL, 32767, -32768, -32768, 32767);
        queue_op(CMD_MUL, 32749, 32719, 32717, 32713); // coprime primes
        queue_op(CMD_DIV, 32749, 32719, 32717, 32713);
        queue_op(CMD_MUL, 5, -3, 6, 10);            // negative denominator kept
        queue_op(CMD_DIV, -1, 1, 1, -1);
        queue_op(CMD_MUL, 16384, 4096, 1024, 8192);
        queue_op(CMD_DIV, -1, -1, -1, -1);
        queue_op(CMD_MUL, -21845, 10922, 21845, -10922);

        // random: mix of full-range, small, shared-factor, extreme and power-of-two
        repeat (N_RANDOM)
        begin
            cmd    = ($urandom_range(0, 1) == 1) ? CMD_DIV : CMD_MUL;
            factor = $urandom_range(1, 200);
            case ($urandom_range(0, 9))
                0, 1, 2: cls = 0;
                3, 4:    cls = 1;
                5, 6, 7: cls = 2;
                8:       cls = 3;
                default: cls = 4;
            endcase
            queue_op(cmd, rand_operand(cls, factor), rand_operand(cls, factor),
                     rand_operand(cls, factor), rand_operand(cls, factor));
        end

        // release reset once the clock is running
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_items) @(posedge clk);
        while (reduced_q.size() > 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (reduced_q.size() > 0)
            report_mismatch("results never delivered", reduced_q.size(), 0);

        $display("checked %0d results from %0d multiply and %0d divide transfers",
                 n_results, n_mul, n_div);
        $display("zero/zero flagged %0d, zero denominator %0d, negative denominator %0d, "
                 , n_zz_flag, n_den_zero, n_neg_den, "mismatches %0d", n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* fraction_mul_div_reduce_unit.f */
sv/fmdr_pkg.sv
sv/fmdr_div.sv
sv/fraction_mul_div_reduce_unit.sv
sv/fmdr_checker.sv
bench/tb_fraction_mul_div_reduce_unit.sv
